@@ src/modbus_read_response_checker_unit_defines.svh @@
// assertion macros for the modbus read response checker
// no dependencies; included by the files that carry assertions
`ifndef MODBUS_READ_RESPONSE_CHECKER_UNIT_DEFINES_SVH
`define MODBUS_READ_RESPONSE_CHECKER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MRRC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MRRC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define MRRC_ASSERT(lbl, clk, rst_n, prop)
`define MRRC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ src/mrrc_pkg.sv @@
// shared types, constants and the crc byte fold for the response checker
// no dependencies
package mrrc_pkg;

    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [7:0]  DEV_ADDR_RESET    = 8'h1A;
    localparam logic [3:0]  EXP_CNT_RESET     = 4'd2;

    localparam logic CFG_DEV_ADDR = 1'b0;
    localparam logic CFG_EXP_CNT  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_HDR = 2'd1,
        ST_CRC = 2'd2
    } t_status;

    typedef struct packed {
        logic latch;
        logic seed;
        logic step;
        logic clr_k;
        logic rd;
        logic load_word;
        logic load_err;
    } t_dp_cmd;

    typedef struct packed {
        logic pos_zero;
        logic frame_end;
        logic bad;
        logic drain_last;
        logic out_free;
    } t_dp_stat;

    function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

endpackage

@@ src/mrrc_ctrl.sv @@
// controller state machine for the response checker
// depends on mrrc_pkg
module mrrc_ctrl
    import mrrc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output logic     o_s_tready,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_BYTE,
        S_END,
        S_ERR,
        S_READ,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.latch = 1'b1;
                    if (i_start) begin
                        n_state = S_SEED;
                    end else if (!i_stat.pos_zero) begin
                        n_state = S_BYTE;
                    end
                end
            end
            S_SEED: begin
                o_cmd.seed = 1'b1;
                n_state    = S_BYTE;
            end
            S_BYTE: begin
                o_cmd.step = 1'b1;
                n_state    = i_stat.frame_end ? S_END : S_IDLE;
            end
            S_END: begin
                if (i_stat.bad) begin
                    n_state = S_ERR;
                end else begin
                    o_cmd.clr_k = 1'b1;
                    n_state     = S_READ;
                end
            end
            S_ERR: begin
                if (i_stat.out_free) begin
                    o_cmd.load_err = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load_word = 1'b1;
                    n_state         = i_stat.drain_last ? S_IDLE : S_READ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

@@ src/mrrc_dp.sv @@
// datapath: config registers, crc, frame position, word store and output register
// depends on mrrc_pkg and the assertion macro header
`include "modbus_read_response_checker_unit_defines.svh"

module mrrc_dp
    import mrrc_pkg::*;
#(
    parameter int MAX_REGS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic [7:0]  i_rx_byte,
    input  t_dp_cmd     i_cmd,
    input  logic        i_m_tready,
    output t_dp_stat    o_stat,
    output logic        o_m_tvalid,
    output logic [23:0] o_m_tdata,
    output logic        o_m_tlast
);

    localparam int NW       = $clog2(MAX_REGS + 1);
    localparam int IW       = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
    localparam int PW       = $clog2(2 * MAX_REGS + 4);
    localparam int LAST_MAX = 2 * MAX_REGS + 3;

    logic [7:0]    r_dev_addr;
    logic [3:0]    r_exp_cnt;
    logic [7:0]    r_byte;
    logic [15:0]   r_crc;
    logic [PW-1:0] r_pos;
    logic          r_hdr;
    logic [7:0]    r_low;
    logic [NW-1:0] r_k;
    logic [15:0]   r_mem [MAX_REGS];
    logic [15:0]   r_rd_word;
    logic          r_out_valid;
    logic [15:0]   r_out_word;
    logic [2:0]    r_out_idx;
    t_status       r_out_status;
    logic          r_out_last;

    logic          w_count_bad;
    logic [NW-1:0] w_n;
    logic [PW-1:0] w_last_pos;
    logic [PW-1:0] w_off;
    logic          w_in_data;
    logic          w_wr_en;
    logic [IW-1:0] w_wr_idx;
    logic          w_frame_end;
    logic          w_hdr_fail;

    always_comb begin
        w_count_bad = (r_exp_cnt == 4'd0) || (32'(r_exp_cnt) > MAX_REGS);
        if (r_exp_cnt == 4'd0) begin
            w_n = NW'(1);
        end else if (w_count_bad) begin
            w_n = NW'(MAX_REGS);
        end else begin
            w_n = NW'(r_exp_cnt);
        end
        w_last_pos  = PW'({w_n, 1'b0}) + PW'(3);
        w_off       = r_pos - PW'(2);
        w_in_data   = (r_pos >= PW'(2)) && (r_pos < (w_last_pos - PW'(1)));
        w_wr_en     = i_cmd.step && w_in_data && w_off[0];
        w_wr_idx    = IW'(w_off >> 1);
        w_frame_end = (r_pos >= w_last_pos);
        w_hdr_fail  = 1'b0;
        if (r_pos == PW'(0)) begin
            w_hdr_fail = (r_byte != FUNC_READ_HOLDING);
        end else if (r_pos == PW'(1)) begin
            w_hdr_fail = w_count_bad || (r_byte != {3'b000, r_exp_cnt, 1'b0});
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr  <= DEV_ADDR_RESET;
            r_exp_cnt   <= EXP_CNT_RESET;
            r_pos       <= '0;
            r_hdr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEV_ADDR: r_dev_addr <= i_cfg_data;
                    CFG_EXP_CNT:  r_exp_cnt  <= i_cfg_data[3:0];
                    default:      r_exp_cnt  <= r_exp_cnt;
                endcase
            end
            if (i_cmd.seed) begin
                r_pos <= '0;
                r_hdr <= 1'b0;
            end else if (i_cmd.step) begin
                r_pos <= w_frame_end ? '0 : r_pos + PW'(1);
                if (w_hdr_fail) begin
                    r_hdr <= 1'b1;
                end
            end
            if (i_cmd.load_word || i_cmd.load_err) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_byte <= i_rx_byte;
        end
        if (i_cmd.seed) begin
            r_crc <= crc_fold(CRC_INIT, r_dev_addr);
        end else if (i_cmd.step) begin
            r_crc <= crc_fold(r_crc, r_byte);
        end
        if (i_cmd.step && w_in_data && !w_off[0]) begin
            r_low <= r_byte;
        end
        if (i_cmd.clr_k) begin
            r_k <= '0;
        end else if (i_cmd.load_word) begin
            r_k <= r_k + NW'(1);
        end
        if (i_cmd.load_err) begin
            r_out_word   <= '0;
            r_out_idx    <= '0;
            r_out_status <= r_hdr ? ST_HDR : ST_CRC;
            r_out_last   <= 1'b1;
        end else if (i_cmd.load_word) begin
            r_out_word   <= r_rd_word;
            r_out_idx    <= 3'(r_k);
            r_out_status <= ST_OK;
            r_out_last   <= o_stat.drain_last;
        end
    end

    // word store
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_idx] <= {r_byte, r_low};
        end
        if (i_cmd.rd) begin
            r_rd_word <= r_mem[IW'(r_k)];
        end
    end

    always_comb begin
        o_stat.pos_zero   = (r_pos == '0);
        o_stat.frame_end  = w_frame_end;
        o_stat.bad        = r_hdr || (r_crc != 16'h0000);
        o_stat.drain_last = (({1'b0, r_k} + (NW + 1)'(1)) == {1'b0, w_n});
        o_stat.out_free   = !r_out_valid || i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_status, r_out_idx, r_out_word};
    assign o_m_tlast  = r_out_last;

    `MRRC_ASSERT(a_pos_bound, i_clk, i_rst_n, (32'(r_pos) <= LAST_MAX))
    `MRRC_ASSERT(a_one_load, i_clk, i_rst_n, !(i_cmd.load_word && i_cmd.load_err))
    `MRRC_ASSERT(a_load_free, i_clk, i_rst_n,
        (i_cmd.load_word || i_cmd.load_err) |-> o_stat.out_free)
    `MRRC_ASSERT(a_err_shape, i_clk, i_rst_n,
        (r_out_valid && (r_out_status != ST_OK)) |-> (r_out_last && (r_out_word == 16'h0000)))

endmodule

@@ src/modbus_read_response_checker_unit.sv @@
// each byte is latched in idle, then folded; a frame-start byte gets an address seed first
// after the last crc byte: end, then the error state loads the error item, or the read and load
// states load each word item in turn (store read) while the receiver keeps up
// output register lets the next frame's bytes be taken while the final item waits downstream
// synchronous active-low reset: idle, position cleared, address 0x1A, register count 2
// depends on mrrc_pkg, mrrc_ctrl, mrrc_dp
module modbus_read_response_checker_unit
    import mrrc_pkg::*;
#(
    parameter int MAX_REGS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // rx_byte
    input  logic        i_s_tuser,  // frame_start
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,  // reg_word, reg_index, status, zero fill
    output logic        o_m_tlast   // last
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    mrrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_start    (i_s_tuser),
        .i_stat     (w_stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    mrrc_dp #(
        .MAX_REGS (MAX_REGS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx_byte  (i_s_tdata),
        .i_cmd      (w_cmd),
        .i_m_tready (i_m_tready),
        .o_stat     (w_stat),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for modbus_read_response_checker_unit: frames with random content,
// header and crc faults, truncation and stray bytes, checked against an in-bench frame tracker
// depends on mrrc_pkg and the rtl of modbus_read_response_checker_unit
module testbench;
    import mrrc_pkg::*;

    localparam int MAX_REGS = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOW_MAX = 10;
    localparam int N_PHASES = 8;
    localparam int SETTLE_CYCLES = 20;

    typedef enum int {
        FR_GOOD,
        FR_BAD_CRC,
        FR_BAD_FUNC,
        FR_BAD_COUNT,
        FR_TRUNC,
        FR_NOISE
    } t_frame_kind;

    typedef struct {
        logic [15:0] word;
        logic [2:0]  idx;
        t_status     st;
        logic        last;
    } t_reg_result;

    class frame_tracker;
        logic [7:0]  dev_addr;
        logic [3:0]  exp_cnt;
        logic [15:0] crc;
        int unsigned pos;
        bit          hdr_bad;
        logic [7:0]  low_hold;
        logic [15:0] words[MAX_REGS];
        t_reg_result awaited[$];
        int unsigned mismatches;
        int unsigned n_words;
        int unsigned n_hdr_err;
        int unsigned n_crc_err;

        function new();
            dev_addr = DEV_ADDR_RESET;
            exp_cnt = EXP_CNT_RESET;
            pos = 0;
            hdr_bad = 0;
            low_hold = 8'h00;
            foreach (words[i]) words[i] = 16'h0000;
            mismatches = 0;
            n_words = 0;
            n_hdr_err = 0;
            n_crc_err = 0;
        endfunction

        // bit-serial form of the reflected modbus crc
        static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            logic fb;
            r = c;
            for (int i = 0; i < 8; i++) begin
                fb = r[0] ^ b[i];
                r = r >> 1;
                if (fb) r = r ^ 16'hA001;
            end
            return r;
        endfunction

        function void set_reg(logic idx, logic [7:0] data);
            if (idx == CFG_DEV_ADDR) dev_addr = data;
            else exp_cnt = data[3:0];
        endfunction

        function int unsigned frame_regs();
            if (exp_cnt == 0) return 1;
            if (exp_cnt > MAX_REGS) return MAX_REGS;
            return exp_cnt;
        endfunction

        // returns 0 when the byte is dropped outside a frame
        function bit take_byte(logic [7:0] b, logic start);
            int unsigned p;
            int unsigned n;
            bit count_bad;
            t_reg_result r;
            if (start) begin
                p = 0;
                hdr_bad = 0;
                crc = crc_step(CRC_INIT, dev_addr);
            end else if (pos == 0) begin
                return 0;
            end else begin
                p = pos;
            end
            crc = crc_step(crc, b);
            count_bad = (exp_cnt < 1) || (exp_cnt > MAX_REGS);
            n = frame_regs();
            if (p == 0) begin
                if (b != FUNC_READ_HOLDING) hdr_bad = 1;
            end else if (p == 1) begin
                if (count_bad || b != {exp_cnt, 1'b0}) hdr_bad = 1;
            end else if (p < 2 * n + 2) begin
                if (((p - 2) & 1) == 0) low_hold = b;
                else words[(p - 2) >> 1] = {b, low_hold};
            end
            if (p < 2 * n + 3) begin
                pos = p + 1;
                return 1;
            end
            pos = 0;
            if (hdr_bad || crc != 16'h0000) begin
                r.word = 16'h0000;
                r.idx = 3'd0;
                r.st = hdr_bad ? ST_HDR : ST_CRC;
                r.last = 1'b1;
                awaited.push_back(r);
                if (hdr_bad) n_hdr_err++;
                else n_crc_err++;
            end else begin
                for (int k = 0; k < n; k++) begin
                    r.word = words[k];
                    r.idx = k[2:0];
                    r.st = ST_OK;
                    r.last = (k == n - 1);
                    awaited.push_back(r);
                    n_words++;
                end
            end
            return 1;
        endfunction

        function void check_result(logic [15:0] word, logic [2:0] idx, logic [1:0] st,
                                   logic last);
            t_reg_result e;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("unexpected result: word %h idx %0d status %0d last %b",
                             word, idx, st, last);
                return;
            end
            e = awaited.pop_front();
            if (word !== e.word || idx !== e.idx || st !== e.st || last !== e.last) begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display({"mismatch: expected word %h idx %0d status %0d last %b, ",
                              "got %h %0d %0d %b"},
                             e.word, e.idx, e.st, e.last, word, idx, st, last);
            end
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [7:0]  cfg_data = 8'h00;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data = 8'h00;
    logic        s_user = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [23:0] m_data;
    logic        m_last;

    frame_tracker tracker;
    int tx_gap_max = 17;
    int rx_stall_max = 17;
    int rx_hold = 0;
    int unsigned sent_items = 0;
    int unsigned cycles = 0;

    modbus_read_response_checker_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),
        .o_m_tlast  (m_last)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_item(logic [7:0] b, logic start);
        int gap;
        gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        s_user <= start;
        do @(posedge clk); while (!s_ready);
        if (tracker.take_byte(b, start)) sent_items++;
    endtask

    task automatic send_frame(t_frame_kind kind, bit extreme);
        logic [7:0]  bytes[$];
        logic [7:0]  v;
        logic [15:0] c;
        int n;
        int len;
        int pick;
        if (kind == FR_NOISE) begin
            repeat ($urandom_range(1, 4)) send_item(8'($urandom_range(0, 255)), 1'b0);
            return;
        end
        n = tracker.frame_regs();
        v = FUNC_READ_HOLDING;
        if (kind == FR_BAD_FUNC) begin
            do v = 8'($urandom_range(0, 255)); while (v == FUNC_READ_HOLDING);
        end
        bytes.push_back(v);
        bytes.push_back({3'b000, tracker.exp_cnt, 1'b0});
        if (kind == FR_BAD_COUNT) bytes[1] = bytes[1] ^ 8'($urandom_range(1, 255));
        for (int i = 0; i < 2 * n; i++)
            bytes.push_back(extreme ? (((i / 2) % 2) ? 8'h00 : 8'hFF)
                                    : 8'($urandom_range(0, 255)));
        c = frame_tracker::crc_step(CRC_INIT, tracker.dev_addr);
        foreach (bytes[i]) c = frame_tracker::crc_step(c, bytes[i]);
        bytes.push_back(c[7:0]);
        bytes.push_back(c[15:8]);
        // function code faults sometimes carry a broken crc too, so header priority gets exercised
        if (kind == FR_BAD_CRC || (kind == FR_BAD_FUNC && $urandom_range(0, 1))) begin
            pick = $urandom_range(0, bytes.size() - 1);
            bytes[pick] = bytes[pick] ^ 8'(1 << $urandom_range(0, 7));
        end
        len = (kind == FR_TRUNC) ? $urandom_range(1, bytes.size() - 1) : bytes.size();
        for (int i = 0; i < len; i++) send_item(bytes[i], i == 0);
    endtask

    task automatic write_reg(logic idx, logic [7:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        tracker.set_reg(idx, data);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge clk); while (tracker.outstanding() != 0);
    endtask

    initial begin
        int stall;
        wait (rst_n === 1'b1);
        forever begin
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            stall = (rx_stall_max == 0) ? 0 : $urandom_range(0, rx_stall_max);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_ready <= 1'b1;
            do @(posedge clk); while (!m_valid);
            tracker.check_result(m_data[15:0], m_data[18:16], m_data[20:19], m_last);
        end
    end

    initial begin
        int unsigned target;
        int unsigned phase_base;
        int r;
        bit paused;
        logic [7:0] addr;
        logic [3:0] cnt;
        t_frame_kind kind;
        tracker = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            tx_gap_max = (ph % 3 == 2) ? 0 : 17;
            rx_stall_max = (ph % 3 == 1) ? 0 : 17;
            if (ph > 0) begin
                drain_results();
                repeat (SETTLE_CYCLES) @(posedge clk);
                addr = 8'($urandom_range(0, 255));
                case (ph)
                    1: begin addr = 8'h00; cnt = 4'd1; end
                    2: begin addr = 8'hFF; cnt = 4'd8; end
                    3: cnt = 4'd0;
                    4: cnt = 4'd15;
                    5: cnt = 4'd9;
                    default: cnt = 4'($urandom_range(1, 8));
                endcase
                write_reg(CFG_DEV_ADDR, addr);
                write_reg(CFG_EXP_CNT, {4'h0, cnt});
                cfg_we <= 1'b0;
            end else begin
                // defaults after reset: good frame with extreme words, stray byte,
                // restart mid-frame, crc fault, function code fault
                send_frame(FR_GOOD, 1'b1);
                send_item(8'h5A, 1'b0);
                send_item(FUNC_READ_HOLDING, 1'b1);
                send_item(8'h04, 1'b0);
                send_frame(FR_BAD_CRC, 1'b0);
                send_frame(FR_BAD_FUNC, 1'b0);
            end
            if (ph == 2) rx_hold = 400;
            phase_base = sent_items;
            target = sent_items + ((ph == 0) ? 30 : 45);
            paused = 0;
            send_frame(FR_GOOD, 1'b0);
            while (sent_items < target) begin
                if (ph % 2 == 1 && !paused && sent_items >= phase_base + 27) begin
                    drain_results();
                    paused = 1;
                end
                r = $urandom_range(0, 19);
                if (r < 12) kind = FR_GOOD;
                else if (r < 14) kind = FR_BAD_CRC;
                else if (r == 14) kind = FR_BAD_FUNC;
                else if (r == 15) kind = FR_BAD_COUNT;
                else if (r < 18) kind = FR_TRUNC;
                else kind = FR_NOISE;
                send_frame(kind, $urandom_range(0, 9) == 0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES + 10) @(posedge clk);
        $display("%0d bytes consumed over %0d register settings, %0d cycles",
                 sent_items, N_PHASES, cycles);
        $display("%0d words, %0d header errors, %0d crc errors predicted, %0d mismatches",
                 tracker.n_words, tracker.n_hdr_err, tracker.n_crc_err, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/mrrc_pkg.sv
src/mrrc_ctrl.sv
src/mrrc_dp.sv
src/modbus_read_response_checker_unit.sv
dv/testbench.sv
